// ===== rtl/assert_macros.svh =====
// Assertion macros for the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bhist_pkg.sv =====
// Types, constants and command/status structs for the byte histogram.
package bhist_pkg;

    localparam int NUM_BINS  = 256;
    localparam int BIN_IDX_W = $clog2(NUM_BINS);
    localparam int CURSOR_W  = BIN_IDX_W + 1;
    localparam int CNT_W     = 8;
    localparam int CHAR_W    = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] ASCII_CR   = 8'h0D;

    // Read address source for the bin memory.
    typedef enum logic [1:0] {
        RD_HOLD   = 2'd0,
        RD_BYTE   = 2'd1,
        RD_CURSOR = 2'd2,
        RD_NEXT   = 2'd3
    } rd_sel_t;

    // Character that goes into the output register.
    typedef enum logic [2:0] {
        CH_BYTE = 3'd0,
        CH_DASH = 3'd1,
        CH_HUND = 3'd2,
        CH_TENS = 3'd3,
        CH_ONES = 3'd4,
        CH_LF   = 3'd5,
        CH_CR   = 3'd6,
        CH_DONE = 3'd7
    } char_sel_t;

    typedef struct packed {
        rd_sel_t   rd_sel;
        logic      cnt_write;
        logic      scan_load;
        logic      cursor_clear;
        logic      out_load;
        char_sel_t out_sel;
    } bhist_cmd_t;

    typedef struct packed {
        logic cursor_over;
        logic scan_hit;
        logic scan_end;
        logic has_hund;
        logic has_tens;
        logic out_free;
    } bhist_stat_t;

endpackage

// ===== rtl/bhist_ctrl.sv =====
// Controller state machine for counting, bin scanning and line emission.
module bhist_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_op,
    input  bhist_pkg::bhist_stat_t stat,
    output bhist_pkg::bhist_cmd_t  cmd
);
    import bhist_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_CNT_WR = 11'b000_0000_0010,
        ST_SCAN   = 11'b000_0000_0100,
        ST_BYTE   = 11'b000_0000_1000,
        ST_DASH   = 11'b000_0001_0000,
        ST_HUND   = 11'b000_0010_0000,
        ST_TENS   = 11'b000_0100_0000,
        ST_ONES   = 11'b000_1000_0000,
        ST_LF     = 11'b001_0000_0000,
        ST_CR     = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        cmd.rd_sel       = RD_HOLD;
        cmd.cnt_write    = 1'b0;
        cmd.scan_load    = 1'b0;
        cmd.cursor_clear = 1'b0;
        cmd.out_load     = 1'b0;
        cmd.out_sel      = CH_BYTE;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (!s_op) begin
                        cmd.rd_sel = RD_BYTE;
                        state_next = ST_CNT_WR;
                    end else if (stat.cursor_over) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.rd_sel = RD_CURSOR;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CNT_WR: begin
                cmd.cnt_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN: begin
                if (stat.scan_hit) begin
                    cmd.scan_load = 1'b1;
                    state_next    = ST_BYTE;
                end else if (stat.scan_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd_sel = RD_NEXT;
                end
            end
            ST_BYTE: begin
                cmd.out_sel = CH_BYTE;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_DASH;
                end
            end
            ST_DASH: begin
                cmd.out_sel = CH_DASH;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.has_hund) begin
                        state_next = ST_HUND;
                    end else if (stat.has_tens) begin
                        state_next = ST_TENS;
                    end else begin
                        state_next = ST_ONES;
                    end
                end
            end
            ST_HUND: begin
                cmd.out_sel = CH_HUND;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_TENS;
                end
            end
            ST_TENS: begin
                cmd.out_sel = CH_TENS;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ONES;
                end
            end
            ST_ONES: begin
                cmd.out_sel = CH_ONES;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_LF;
                end
            end
            ST_LF: begin
                cmd.out_sel = CH_LF;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_CR;
                end
            end
            ST_CR: begin
                cmd.out_sel = CH_CR;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DONE: begin
                cmd.out_sel = CH_DONE;
                if (stat.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.cursor_clear = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bhist_dp.sv =====
// Datapath: bin memory with valid flags, report cursor, digit split, output register.
`include "assert_macros.svh"
module bhist_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_byte,
    input  bhist_pkg::bhist_cmd_t         cmd,
    output bhist_pkg::bhist_stat_t        stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bhist_pkg::CHAR_W-1:0]  m_char,
    output logic                          m_last,
    output logic                          m_done
);
    import bhist_pkg::*;

    logic [CNT_W-1:0]     bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]  bin_valid_reg;
    logic [CNT_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;
    logic [BIN_IDX_W-1:0] addr_reg;
    logic [BIN_IDX_W-1:0] rd_addr;
    logic                 in_range_reg;
    logic [CURSOR_W-1:0]  cursor_reg;
    logic [BIN_IDX_W-1:0] bin_reg;
    logic [1:0]           hund_reg;
    logic [6:0]           rem_reg;
    logic                 has_hund_reg;
    logic                 has_tens_reg;
    logic                 m_valid_reg;
    logic [CHAR_W-1:0]    m_char_reg;
    logic                 m_last_reg;
    logic                 m_done_reg;

    logic [CNT_W-1:0]     cnt_val;
    logic [1:0]           hund_next;
    logic [6:0]           rem_next;
    logic [14:0]          tens_prod;
    logic [3:0]           tens_dig;
    logic [3:0]           ones_dig;
    logic [CHAR_W-1:0]    char_next;
    logic                 out_free;

    // Select the bin memory read address
    always_comb begin
        case (cmd.rd_sel)
            RD_BYTE:   rd_addr = s_byte[BIN_IDX_W-1:0];
            RD_CURSOR: rd_addr = cursor_reg[BIN_IDX_W-1:0];
            RD_NEXT:   rd_addr = addr_reg + BIN_IDX_W'(1);
            default:   rd_addr = addr_reg;
        endcase
    end

    // Unwritten bins read as zero
    assign cnt_val = rd_valid_reg ? rd_data_reg : '0;

    // Bin memory: registered read, write back incremented count
    always_ff @(posedge aclk) begin
        if (cmd.cnt_write && in_range_reg) begin
            bin_mem[addr_reg] <= cnt_val + CNT_W'(1);
        end
        rd_data_reg <= bin_mem[rd_addr];
        addr_reg    <= rd_addr;
        if (cmd.rd_sel == RD_BYTE) begin
            in_range_reg <= ({1'b0, s_byte} < 9'(NUM_BINS));
        end
    end

    // Per-bin written flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= bin_valid_reg[rd_addr];
            if (cmd.cnt_write && in_range_reg) begin
                bin_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Split the count into hundreds and remainder
    always_comb begin
        if (cnt_val >= CNT_W'(200)) begin
            hund_next = 2'd2;
            rem_next  = 7'(cnt_val - CNT_W'(200));
        end else if (cnt_val >= CNT_W'(100)) begin
            hund_next = 2'd1;
            rem_next  = 7'(cnt_val - CNT_W'(100));
        end else begin
            hund_next = 2'd0;
            rem_next  = 7'(cnt_val);
        end
    end

    // Latch the found bin and advance the cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else if (cmd.cursor_clear) begin
            cursor_reg <= '0;
        end else if (cmd.scan_load) begin
            cursor_reg <= {1'b0, addr_reg} + CURSOR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_load) begin
            bin_reg      <= addr_reg;
            hund_reg     <= hund_next;
            rem_reg      <= rem_next;
            has_hund_reg <= (cnt_val >= CNT_W'(100));
            has_tens_reg <= (cnt_val >= CNT_W'(10));
        end
    end

    // Tens by reciprocal multiply (exact below 100), ones by subtraction
    assign tens_prod = 15'(rem_reg) * 15'd205;
    assign tens_dig  = tens_prod[14:11];
    assign ones_dig  = 4'(rem_reg - 7'({3'b0, tens_dig}) * 7'd10);

    // Pick the character for the output register
    always_comb begin
        case (cmd.out_sel)
            CH_BYTE: char_next = CHAR_W'(bin_reg);
            CH_DASH: char_next = ASCII_DASH;
            CH_HUND: char_next = ASCII_ZERO + CHAR_W'(hund_reg);
            CH_TENS: char_next = ASCII_ZERO + CHAR_W'(tens_dig);
            CH_ONES: char_next = ASCII_ZERO + CHAR_W'(ones_dig);
            CH_LF:   char_next = ASCII_LF;
            CH_CR:   char_next = ASCII_CR;
            default: char_next = '0;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;

    // Output register: load on command, drop after transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_char_reg <= char_next;
            m_last_reg <= (cmd.out_sel == CH_CR);
            m_done_reg <= (cmd.out_sel == CH_DONE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_char   = m_char_reg;
    assign m_last   = m_last_reg;
    assign m_done   = m_done_reg;

    assign stat.cursor_over = (cursor_reg >= CURSOR_W'(NUM_BINS));
    assign stat.scan_hit    = (cnt_val != '0);
    assign stat.scan_end    = (addr_reg == BIN_IDX_W'(NUM_BINS - 1));
    assign stat.has_hund    = has_hund_reg;
    assign stat.has_tens    = has_tens_reg;
    assign stat.out_free    = out_free;

    `ASSERT_IMPLIES(a_load_when_free, aclk, aresetn, cmd.out_load, out_free)
    `ASSERT_NEXT(a_write_follows_read, aclk, aresetn, cmd.rd_sel == RD_BYTE, cmd.cnt_write)
    `ASSERT_IMPLIES(a_done_is_null, aclk, aresetn, m_valid_reg && m_done_reg, m_char_reg == '0)
    `ASSERT_IMPLIES(a_cursor_bound, aclk, aresetn, 1'b1, cursor_reg <= CURSOR_W'(NUM_BINS))

endmodule

// ===== rtl/byte_histogram_with_text_report.sv =====
// Top level of the byte histogram with text report.
//
//  channel  direction  tdata                 tuser           tlast
//  s_       in         [7:0] byte_value      [0] op          -
//  m_       out        [7:0] out_char        [0] report_done [0] last_of_line
//
// A count transfer issues a bin memory read, then the write-back.
// A report transfer scans the bins one read at a time (single read port
// of the bin memory), then loads the line's characters one by one.
// Reset clears the per-bin written flags at once; no clearing pass follows.
// While m_tready is low a line in progress holds at its next character and
// s_tready stays low until the line's last character is loaded.
module byte_histogram_with_text_report (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [0:0] s_tuser,   // [0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,
    output logic [0:0] m_tuser    // [0] report_done
);
    import bhist_pkg::*;

    bhist_cmd_t  cmd;
    bhist_stat_t stat;
    logic        done_flag;

    bhist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    bhist_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_byte   (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_tdata),
        .m_last   (m_tlast),
        .m_done   (done_flag)
    );

    assign m_tuser = done_flag;

endmodule
